// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the port-level checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion, checked during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hdl/pptbq_pkg.sv -----
// ----------------------------------------------------------------------------
// pptbq_pkg
// Codes, reset values and shared types of the per-peer token bucket queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pptbq_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_LEAVE   = 2'd2;
  localparam logic [1:0] OP_DISC    = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_BAD     = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_HOST  = 2'd0;
  localparam logic [1:0] CFG_BURST = 2'd1;
  localparam logic [1:0] CFG_RATE  = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  // configuration reset values
  localparam logic        HOST_RESET  = 1'b1;
  localparam logic [15:0] BURST_RESET = 16'd8000;
  localparam logic [9:0]  RATE_RESET  = 10'd10;
  localparam logic [4:0]  LIMIT_RESET = 5'd16;

  localparam logic [15:0] TOKEN_COST = 16'd1000;

  // elapsed time is clamped to 2^16 ms: beyond that any nonzero rate fills the bucket
  localparam int ELAPSED_W = 17;
  localparam int PROD_W    = 27;

  typedef struct packed {
    logic [15:0] level;
    logic        spend;
  } refill_res_t;

  typedef struct packed {
    logic ld_elapsed;
    logic ld_prod;
  } refill_ctl_t;

endpackage

// ----- hdl/per_peer_token_bucket_queue_core.sv -----
// ----------------------------------------------------------------------------
// per_peer_token_bucket_queue_core
// Per-peer intent FIFOs with token bucket release, held in two RAMs.
// ----------------------------------------------------------------------------
// One item is worked at a time. An enqueue that passes the slot and enable
// checks goes through S_ENQ, accepted or full, before its result in S_RESP;
// an enqueue refused for a bad slot or a disabled block, a tick on a disabled
// block and a peer-left go straight to S_RESP. A tick visits slots 1 to
// PEERS-1 in turn: S_TK_RD and S_TK_SUB for each, plus S_TK_MUL and S_TK_UPD
// for a slot with queued intents, set by the registered read of the slot state
// RAM followed by the two-stage refill unit; S_FIN gives its final result.
// Disconnect, and reset, run a clearing pass over all PEERS slots of the slot
// state RAM; no input beat is taken during it. Results leave through an output
// register, so a stalled output holds the block only when a further result is due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_peer_token_bucket_queue_core #(
  parameter int PEERS       = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  peer_slot,
  input  logic [47:0] intent_word,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  out_slot,
  output logic [47:0] out_intent,
  output logic        last
);

  import pptbq_pkg::*;

  localparam int SW = $clog2(PEERS);
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int NI = PEERS * QUEUE_DEPTH;
  localparam int AW = (NI > 1) ? $clog2(NI) : 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ENQ    = 4'd2;
  localparam logic [3:0] S_RESP   = 4'd3;
  localparam logic [3:0] S_TK_RD  = 4'd4;
  localparam logic [3:0] S_TK_SUB = 4'd5;
  localparam logic [3:0] S_TK_MUL = 4'd6;
  localparam logic [3:0] S_TK_UPD = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
    logic [15:0]   level;
    logic [47:0]   last_ms;
  } slot_state_t;

  localparam int SSW = $bits(slot_state_t);

  // configuration
  logic        host_en;
  logic [15:0] burst;
  logic [9:0]  rate;
  logic [4:0]  qlimit;

  // control
  logic [3:0]    state;
  logic [SW-1:0] cur;
  logic          rst_pass;
  logic [SW-1:0] slot_r;
  logic [47:0]   word_r;
  logic [47:0]   now_r;
  logic [2:0]    resp_kind;
  logic [3:0]    resp_slot;
  slot_state_t   st;
  logic          held_valid;
  logic [3:0]    held_slot;
  logic [47:0]   held_intent;

  // memory ports
  logic          st_we, st_re;
  logic [SW-1:0] st_waddr, st_raddr;
  slot_state_t   st_wdata, st_rdata;
  logic          iq_we, iq_re;
  logic [AW-1:0] iq_waddr, iq_raddr;
  logic [47:0]   iq_rdata;

  refill_ctl_t   rf_ctl;
  refill_res_t   rf_res;

  logic          in_fire, out_free, slot_ok, slot_in_range, full;
  logic [SW-1:0] in_idx;
  logic [LW-1:0] lim_eff;
  logic [CW:0]   pos_sum;
  logic [HW-1:0] pos;
  logic [HW:0]   head_inc;
  logic [HW-1:0] head_next;
  slot_state_t   clear_val;
  logic          upd_go;
  logic          last_slot;

  logic          emit;
  logic [2:0]    e_kind;
  logic [3:0]    e_slot;
  logic [47:0]   e_intent;
  logic          e_last;

  assign in_ready      = (state == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_free      = !out_valid || out_ready;
  assign in_idx        = peer_slot[SW-1:0];
  assign slot_in_range = ({1'b0, peer_slot} < 5'(PEERS));
  assign slot_ok       = (peer_slot != 4'd0) && slot_in_range;
  assign last_slot     = (cur == SW'(PEERS - 1));

  assign lim_eff = (LW'(qlimit) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : LW'(qlimit);
  assign full    = (LW'(st_rdata.count) >= lim_eff);

  // tail position, wrapped once
  always_comb begin
    pos_sum = (CW + 1)'(st_rdata.head) + (CW + 1)'(st_rdata.count);
    if (pos_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      pos = HW'(pos_sum - (CW + 1)'(QUEUE_DEPTH));
    end else begin
      pos = HW'(pos_sum);
    end
    head_inc  = (HW + 1)'(st.head) + (HW + 1)'(1);
    head_next = (head_inc == (HW + 1)'(QUEUE_DEPTH)) ? HW'(0) : head_inc[HW-1:0];
  end

  always_comb begin
    clear_val.head    = '0;
    clear_val.count   = '0;
    clear_val.level   = rst_pass ? BURST_RESET : burst;
    clear_val.last_ms = 48'd0;
  end

  // a release may only proceed when the held one can be pushed out
  assign upd_go = !(rf_res.spend && held_valid) || out_free;

  // memory ports and result emission
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = cur;
    st_wdata  = clear_val;
    st_re     = 1'b0;
    st_raddr  = cur;
    iq_we     = 1'b0;
    iq_waddr  = AW'(slot_r) * AW'(QUEUE_DEPTH) + AW'(pos);
    iq_re     = 1'b0;
    iq_raddr  = AW'(cur) * AW'(QUEUE_DEPTH) + AW'(st_rdata.head);
    rf_ctl    = '0;
    emit      = 1'b0;
    e_kind    = resp_kind;
    e_slot    = resp_slot;
    e_intent  = 48'd0;
    e_last    = 1'b1;
    case (state)
      S_CLEAR: begin
        st_we = 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op == OP_ENQUEUE) begin
            st_re    = 1'b1;
            st_raddr = in_idx;
          end else if (op == OP_LEAVE && slot_in_range) begin
            st_we    = 1'b1;
            st_waddr = in_idx;
          end
        end
      end
      S_ENQ: begin
        if (!full) begin
          iq_we          = 1'b1;
          st_we          = 1'b1;
          st_waddr       = slot_r;
          st_wdata       = st_rdata;
          st_wdata.count = st_rdata.count + CW'(1);
        end
      end
      S_RESP: begin
        emit = out_free;
      end
      S_TK_RD: begin
        st_re = 1'b1;
      end
      S_TK_SUB: begin
        rf_ctl.ld_elapsed = 1'b1;
        iq_re             = (st_rdata.count != '0);
      end
      S_TK_MUL: begin
        rf_ctl.ld_prod = 1'b1;
      end
      S_TK_UPD: begin
        if (upd_go) begin
          st_we            = 1'b1;
          st_wdata         = st;
          st_wdata.level   = rf_res.level;
          st_wdata.last_ms = now_r;
          if (rf_res.spend) begin
            st_wdata.head  = head_next;
            st_wdata.count = st.count - CW'(1);
            if (held_valid) begin
              emit     = 1'b1;
              e_kind   = KIND_RELEASE;
              e_slot   = held_slot;
              e_intent = held_intent;
              e_last   = 1'b0;
            end
          end
        end
      end
      S_FIN: begin
        emit = out_free;
        if (held_valid) begin
          e_kind   = KIND_RELEASE;
          e_slot   = held_slot;
          e_intent = held_intent;
        end else begin
          e_kind = KIND_DONE;
          e_slot = 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cur        <= '0;
      rst_pass   <= 1'b1;
      held_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (last_slot) begin
            rst_pass  <= 1'b0;
            resp_kind <= KIND_DONE;
            resp_slot <= 4'd0;
            state     <= rst_pass ? S_IDLE : S_RESP;
          end else begin
            cur <= cur + SW'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            slot_r <= in_idx;
            word_r <= intent_word;
            now_r  <= now_ms;
            case (op)
              OP_ENQUEUE: begin
                resp_slot <= peer_slot;
                if (!host_en || !slot_ok) begin
                  resp_kind <= KIND_BAD;
                  state     <= S_RESP;
                end else begin
                  state <= S_ENQ;
                end
              end
              OP_TICK: begin
                resp_kind <= KIND_DONE;
                resp_slot <= 4'd0;
                if (!host_en) begin
                  state <= S_RESP;
                end else begin
                  cur        <= SW'(1);
                  held_valid <= 1'b0;
                  state      <= S_TK_RD;
                end
              end
              OP_LEAVE: begin
                resp_kind <= KIND_DONE;
                resp_slot <= peer_slot;
                state     <= S_RESP;
              end
              default: begin
                cur   <= '0;
                state <= S_CLEAR;
              end
            endcase
          end
        end
        S_ENQ: begin
          resp_kind <= full ? KIND_FULL : KIND_ACCEPT;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_TK_RD: begin
          state <= S_TK_SUB;
        end
        S_TK_SUB: begin
          st <= st_rdata;
          if (st_rdata.count != '0) begin
            state <= S_TK_MUL;
          end else if (last_slot) begin
            state <= S_FIN;
          end else begin
            cur   <= cur + SW'(1);
            state <= S_TK_RD;
          end
        end
        S_TK_MUL: begin
          state <= S_TK_UPD;
        end
        S_TK_UPD: begin
          if (upd_go) begin
            if (rf_res.spend) begin
              held_valid  <= 1'b1;
              held_slot   <= 4'(cur);
              held_intent <= iq_rdata;
            end
            if (last_slot) begin
              state <= S_FIN;
            end else begin
              cur   <= cur + SW'(1);
              state <= S_TK_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_en <= HOST_RESET;
      burst   <= BURST_RESET;
      rate    <= RATE_RESET;
      qlimit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOST:  host_en <= cfg_data[0];
        CFG_BURST: burst   <= cfg_data;
        CFG_RATE:  rate    <= cfg_data[9:0];
        CFG_LIMIT: qlimit  <= cfg_data[4:0];
        default:   host_en <= host_en;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= e_kind;
      out_slot   <= e_slot;
      out_intent <= e_intent;
      last       <= e_last;
    end
  end

  pptbq_ram #(
    .WIDTH (SSW),
    .DEPTH (PEERS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  pptbq_ram #(
    .WIDTH (48),
    .DEPTH (NI)
  ) u_intent_ram (
    .clk   (clk),
    .we    (iq_we),
    .waddr (iq_waddr),
    .wdata (word_r),
    .re    (iq_re),
    .raddr (iq_raddr),
    .rdata (iq_rdata)
  );

  pptbq_refill u_refill (
    .clk     (clk),
    .ctl     (rf_ctl),
    .now_ms  (now_r),
    .last_ms (st_rdata.last_ms),
    .level   (st_rdata.level),
    .burst   (burst),
    .rate    (rate),
    .res     (rf_res)
  );

endmodule

// ----- hdl/pptbq_ram.sv -----
// ----------------------------------------------------------------------------
// pptbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pptbq_refill.sv -----
// ----------------------------------------------------------------------------
// pptbq_refill
// Two-stage bucket refill: elapsed time, then rate product, then cap and spend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptbq_refill (
  input  logic                     clk,
  input  pptbq_pkg::refill_ctl_t   ctl,
  input  logic [47:0]              now_ms,
  input  logic [47:0]              last_ms,
  input  logic [15:0]              level,
  input  logic [15:0]              burst,
  input  logic [9:0]               rate,
  output pptbq_pkg::refill_res_t   res
);

  import pptbq_pkg::*;

  logic [47:0]          elapsed;
  logic [ELAPSED_W-1:0] elapsed_c;
  logic                 refill_ok;

  logic [ELAPSED_W-1:0] el_r;
  logic                 ok_r;
  logic [15:0]          lvl_r;

  logic [PROD_W-1:0]    prod;
  logic                 ok_p;
  logic [15:0]          lvl_p;

  logic [PROD_W:0]      sum;
  logic [15:0]          lvl_new;

  always_comb begin
    elapsed   = now_ms - last_ms;
    refill_ok = (last_ms != 48'd0) && (now_ms > last_ms);
    if (elapsed[47:16] != 32'd0) begin
      elapsed_c = {1'b1, 16'd0};
    end else begin
      elapsed_c = {1'b0, elapsed[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_elapsed) begin
      el_r  <= elapsed_c;
      ok_r  <= refill_ok;
      lvl_r <= level;
    end
    if (ctl.ld_prod) begin
      prod  <= PROD_W'(rate) * PROD_W'(el_r);
      ok_p  <= ok_r;
      lvl_p <= lvl_r;
    end
  end

  // cap only applies when a refill took place
  always_comb begin
    sum = (PROD_W + 1)'(lvl_p) + (PROD_W + 1)'(prod);
    if (!ok_p) begin
      lvl_new = lvl_p;
    end else if (sum > (PROD_W + 1)'(burst)) begin
      lvl_new = burst;
    end else begin
      lvl_new = sum[15:0];
    end
    res.spend = (lvl_new >= TOKEN_COST);
    res.level = res.spend ? (lvl_new - TOKEN_COST) : lvl_new;
  end

endmodule

// ----- hdl/pptbq_checker.sv -----
// ----------------------------------------------------------------------------
// pptbq_checker
// Port-level checks on the per-peer token bucket queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pptbq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [3:0]  out_slot,
  input logic [47:0] out_intent,
  input logic        last
);

  import pptbq_pkg::*;

  logic        stalled;
  logic        non_release;
  logic [55:0] beat;

  assign stalled     = out_valid && !out_ready;
  assign non_release = out_valid && (kind != KIND_RELEASE);
  assign beat        = {kind, out_slot, out_intent, last};

  // hold a stalled result beat
  `ASSERT_CLKD(a_out_hold, clk, rst, (stalled |=> out_valid && $stable(beat)), "stalled beat changed")

  // only a release carries an intent
  `ASSERT_CLKD(a_intent_zero, clk, rst, (non_release |-> out_intent == 48'd0), "intent on non-release")

  // every non-release result closes its item
  `ASSERT_CLKD(a_single_last, clk, rst, (non_release |-> last), "non-release without last")

  // one item at a time: busy right after a beat is taken
  `ASSERT_CLKD(a_busy_after_take, clk, rst, (in_valid && in_ready |=> !in_ready), "taken while busy")

endmodule

bind per_peer_token_bucket_queue_core pptbq_checker u_pptbq_checker (.*);

// ----- tb/pptbq_admission_checker.sv -----
// ----------------------------------------------------------------------------
// pptbq_admission_checker
// Watches the config port and both beat channels of the per-peer token bucket
// queue, keeps its own copy of the queues, buckets and registers, predicts the
// results of every accepted input beat and compares each result beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptbq_admission_checker #(
  parameter int PEERS       = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  peer_slot,
  input  logic [47:0] intent_word,
  input  logic [47:0] now_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [3:0]  out_slot,
  input  logic [47:0] out_intent,
  input  logic        last,
  output int          pending,
  output int          fails
);
  import pptbq_pkg::*;

  localparam int DUE_DEPTH = 64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [47:0] intent;
    logic        last;
  } admit_result_t;

  logic [47:0] intent_mem [PEERS][QUEUE_DEPTH];
  int unsigned fifo_head  [PEERS];
  int unsigned fifo_count [PEERS];
  logic [15:0] bucket     [PEERS];
  logic [47:0] refill_ms  [PEERS];

  logic        host_en;
  logic [15:0] burst;
  logic [9:0]  rate;
  logic [4:0]  limit;

  // predicted results, oldest at due_rd
  admit_result_t due_fifo [DUE_DEPTH];
  int            due_rd;
  int            due_wr;
  int            reported;

  function automatic admit_result_t result_of(input logic [2:0] k, input logic [3:0] s,
                                              input logic [47:0] w, input logic l);
    admit_result_t r;
    r.kind   = k;
    r.slot   = s;
    r.intent = w;
    r.last   = l;
    return r;
  endfunction

  function automatic void due_put(input admit_result_t r);
    due_fifo[due_wr % DUE_DEPTH] = r;
    due_wr++;
  endfunction

  function automatic admit_result_t due_take();
    admit_result_t r;
    r = due_fifo[due_rd % DUE_DEPTH];
    due_rd++;
    return r;
  endfunction

  task automatic empty_slot(input int s);
    fifo_head[s]  = 0;
    fifo_count[s] = 0;
    bucket[s]     = burst;
    refill_ms[s]  = 48'd0;
  endtask

  // refill from elapsed time (not on first use), cap at burst, then try to spend
  task automatic spend_token(input int s, input logic [47:0] now, output logic spent);
    logic [63:0] lvl;
    logic [63:0] gain;
    lvl = {48'd0, bucket[s]};
    if (refill_ms[s] != 48'd0 && now > refill_ms[s]) begin
      gain = {54'd0, rate} * {16'd0, now - refill_ms[s]};
      lvl  = lvl + gain;
      if (lvl > {48'd0, burst}) lvl = {48'd0, burst};
    end
    refill_ms[s] = now;
    spent = (lvl >= {48'd0, TOKEN_COST});
    bucket[s] = spent ? lvl[15:0] - TOKEN_COST : lvl[15:0];
  endtask

  task automatic predict_admission(input logic [1:0] o, input logic [3:0] s,
                                   input logic [47:0] w, input logic [47:0] now);
    int unsigned   lim;
    int unsigned   pos;
    int            p;
    int            n;
    logic          spent;
    admit_result_t freed [PEERS];
    admit_result_t r;
    case (o)
      OP_ENQUEUE: begin
        lim = (limit > QUEUE_DEPTH) ? QUEUE_DEPTH : limit;
        if (!host_en || s < 1 || s >= PEERS) begin
          due_put(result_of(KIND_BAD, s, 48'd0, 1'b1));
        end else if (fifo_count[s] >= lim) begin
          due_put(result_of(KIND_FULL, s, 48'd0, 1'b1));
        end else begin
          pos = (fifo_head[s] + fifo_count[s]) % QUEUE_DEPTH;
          intent_mem[s][pos] = w;
          fifo_count[s] = fifo_count[s] + 1;
          due_put(result_of(KIND_ACCEPT, s, 48'd0, 1'b1));
        end
      end
      OP_TICK: begin
        n = 0;
        if (host_en) begin
          for (p = 1; p < PEERS; p++) begin
            if (fifo_count[p] != 0) begin
              spend_token(p, now, spent);
              if (spent) begin
                freed[n] = result_of(KIND_RELEASE, p[3:0], intent_mem[p][fifo_head[p]], 1'b0);
                fifo_head[p]  = (fifo_head[p] + 1) % QUEUE_DEPTH;
                fifo_count[p] = fifo_count[p] - 1;
                n++;
              end
            end
          end
        end
        if (n == 0) begin
          due_put(result_of(KIND_DONE, 4'd0, 48'd0, 1'b1));
        end
        for (p = 0; p < n; p++) begin
          r = freed[p];
          r.last = (p == n - 1);
          due_put(r);
        end
      end
      OP_LEAVE: begin
        // slots beyond the peer count clear nothing but still answer
        if (s < PEERS) empty_slot(s);
        due_put(result_of(KIND_DONE, s, 48'd0, 1'b1));
      end
      default: begin
        for (p = 0; p < PEERS; p++) empty_slot(p);
        due_put(result_of(KIND_DONE, 4'd0, 48'd0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    admit_result_t got;
    admit_result_t want;
    int            p;
    if (rst) begin
      host_en = HOST_RESET;
      burst   = BURST_RESET;
      rate    = RATE_RESET;
      limit   = LIMIT_RESET;
      for (p = 0; p < PEERS; p++) empty_slot(p);
      due_rd   = 0;
      due_wr   = 0;
      fails    = 0;
      reported = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = result_of(kind, out_slot, out_intent, last);
        if (due_wr == due_rd) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result beat with nothing expected: kind %0d slot %0d intent %h last %0d",
                     $time, got.kind, got.slot, got.intent, got.last);
          end
        end else begin
          want = due_take();
          if (got.kind != want.kind || got.slot != want.slot ||
              got.intent != want.intent || got.last != want.last) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("%0t: result mismatch: expected kind %0d slot %0d intent %h last %0d",
                       $time, want.kind, want.slot, want.intent, want.last);
              $display("%0t:                  got kind %0d slot %0d intent %h last %0d",
                       $time, got.kind, got.slot, got.intent, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOST:  host_en = cfg_data[0];
          CFG_BURST: burst   = cfg_data;
          CFG_RATE:  rate    = cfg_data[9:0];
          CFG_LIMIT: limit   = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_admission(op, peer_slot, intent_word, now_ms);
    end
    pending = due_wr - due_rd;
  end

endmodule

// ----- tb/per_peer_token_bucket_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// per_peer_token_bucket_queue_core_tb
// Drives enqueue, tick, peer-left and disconnect beats into the core with
// random gaps and output stalls, across several register settings including
// the extremes, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_peer_token_bucket_queue_core_tb;
  import pptbq_pkg::*;

  localparam int PEERS         = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 4 * PEERS + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 7;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [3:0]  peer_slot;
  logic [47:0] intent_word;
  logic [47:0] now_ms;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [3:0]  out_slot;
  logic [47:0] out_intent;
  logic        last;

  int pending;
  int fails;
  int sent = 0;
  int idle_cycles = 0;

  per_peer_token_bucket_queue_core #(
    .PEERS(PEERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (.*);

  pptbq_admission_checker #(
    .PEERS(PEERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) admission_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // give up when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("per_peer_token_bucket_queue_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: hold out_ready low at random before a beat, except for the first twelve beats of every forty
  initial begin : result_sink
    int unsigned stall;
    int          taken;
    out_ready = 1'b0;
    taken = 0;
    forever begin
      @(negedge clk);
      stall = ((taken % 40) < 12) ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  task automatic send_beat(input logic [1:0] o, input logic [3:0] s,
                           input logic [47:0] w, input logic [47:0] t);
    int unsigned gap;
    gap = ((sent % 40) < 12) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    peer_slot   <= s;
    intent_word <= w;
    now_ms      <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
    @(negedge clk);
  endtask

  // hold the input until every predicted result is out and the core is quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic host, input logic [15:0] cap,
                                input logic [9:0] per_ms, input logic [4:0] lim);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOST;
    cfg_data  <= {15'd0, host};
    @(negedge clk);
    cfg_index <= CFG_BURST;
    cfg_data  <= cap;
    @(negedge clk);
    cfg_index <= CFG_RATE;
    cfg_data  <= {6'd0, per_ms};
    @(negedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= {11'd0, lim};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          roll;
    int          pick;
    int          enq_cut;
    int          tick_cut;
    int          leave_cut;
    logic        fill;
    logic [63:0] rnd;
    logic [63:0] rnd2;
    logic [3:0]  slot;
    logic [3:0]  hot_slot;
    logic [47:0] clock_ms;
    logic [15:0] r_burst;
    logic [9:0]  r_rate;
    logic [4:0]  r_limit;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_HOST;
    cfg_data    = 16'd0;
    in_valid    = 1'b0;
    op          = OP_ENQUEUE;
    peer_slot   = 4'd0;
    intent_word = 48'd0;
    now_ms      = 48'd0;
    clock_ms    = 48'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bad slots, then a few intents, ticks, peer-lefts and a disconnect on the reset settings
    send_beat(OP_ENQUEUE, 4'd0, '1, 48'd0);
    send_beat(OP_ENQUEUE, 4'd15, 48'h0123_4567_89AB, 48'd0);
    send_beat(OP_ENQUEUE, 4'(PEERS), 48'h0000_0000_0001, 48'd0);
    send_beat(OP_ENQUEUE, 4'd1, '1, '1);
    send_beat(OP_ENQUEUE, 4'd1, 48'd0, 48'd0);
    send_beat(OP_ENQUEUE, 4'(PEERS - 1), 48'h5555_5555_5555, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd100);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd50);
    send_beat(OP_TICK, 4'd15, '1, '1);
    send_beat(OP_ENQUEUE, 4'd3, 48'hAAAA_AAAA_AAAA, 48'd0);
    send_beat(OP_LEAVE, 4'd3, 48'd0, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd200);
    send_beat(OP_LEAVE, 4'd0, 48'd0, 48'd0);
    send_beat(OP_LEAVE, 4'd12, 48'd0, 48'd0);
    send_beat(OP_ENQUEUE, 4'd2, 48'h1234_5678_9ABC, 48'd0);
    send_beat(OP_DISC, 4'd0, 48'd0, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd300);

    apply_settings(1'b1, 16'd8000, 10'd10, 5'd1);
    send_beat(OP_ENQUEUE, 4'd2, 48'hFEDC_BA98_7654, 48'd0);
    send_beat(OP_ENQUEUE, 4'd2, 48'h0F0F_0F0F_0F0F, 48'd0);
    apply_settings(1'b1, 16'd8000, 10'd10, 5'd0);
    send_beat(OP_ENQUEUE, 4'd4, 48'h00FF_00FF_00FF, 48'd0);
    apply_settings(1'b0, 16'd8000, 10'd10, 5'd16);
    send_beat(OP_ENQUEUE, 4'd2, 48'h0000_FFFF_0000, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd400);
    // burst below the stored level: first use keeps the level, the next refill trims it
    apply_settings(1'b1, 16'd1000, 10'd0, 5'd16);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd500);
    send_beat(OP_ENQUEUE, 4'd2, 48'hC3C3_C3C3_C3C3, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd600);
    send_beat(OP_ENQUEUE, 4'd2, 48'h3C3C_3C3C_3C3C, 48'd0);
    send_beat(OP_TICK, 4'd0, 48'd0, 48'd700);

    clock_ms = 48'd1000;
    for (phase = 0; phase < PHASES; phase++) begin
      r_burst = 16'($urandom_range(1000, 65535));
      r_rate  = 10'($urandom_range(0, 1000));
      r_limit = 5'($urandom_range(1, 16));
      case (phase)
        0:       apply_settings(1'b1, 16'd8000, 10'd10, 5'd16);
        1:       apply_settings(1'b1, 16'd1000, 10'd0, 5'd31);
        2:       apply_settings(1'b0, 16'd65535, 10'd1000, 5'd4);
        3:       apply_settings(1'b1, 16'd65535, 10'd1000, 5'd0);
        5:       apply_settings(1'b1, 16'd1000, 10'd1, 5'd2);
        default: apply_settings(1'b1, r_burst, r_rate, r_limit);
      endcase
      // the fill phase piles intents onto one slot to reach the queue depth
      fill      = (phase == 1);
      hot_slot  = 4'($urandom_range(1, PEERS - 1));
      enq_cut   = fill ? 16 : 10;
      tick_cut  = fill ? 19 : 17;
      leave_cut = fill ? 20 : 19;
      for (n = 0; n < (fill ? 40 : 20); n++) begin
        roll = $urandom_range(0, 19);
        rnd  = {$urandom, $urandom};
        rnd2 = {$urandom, $urandom};
        if (roll < enq_cut) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) slot = 4'($urandom_range(0, 15));
          else if (pick < (fill ? 9 : 5)) slot = hot_slot;
          else slot = 4'($urandom_range(1, PEERS - 1));
          send_beat(OP_ENQUEUE, slot, rnd[47:0], rnd2[47:0]);
        end else if (roll < tick_cut) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) clock_ms = rnd2[47:0];
          else if (pick == 1) clock_ms = '1;
          else if (pick == 2) clock_ms = clock_ms;
          else if (pick == 3) clock_ms = clock_ms + 48'($urandom_range(60000, 200000));
          else if (pick == 4) clock_ms = 48'd0;
          else clock_ms = clock_ms + 48'($urandom_range(1, 400));
          send_beat(OP_TICK, rnd[51:48], rnd[47:0], clock_ms);
        end else if (roll < leave_cut) begin
          pick = $urandom_range(0, 9);
          slot = (pick < 3) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, PEERS - 1));
          send_beat(OP_LEAVE, slot, rnd[47:0], rnd2[47:0]);
        end else begin
          send_beat(OP_DISC, rnd[51:48], rnd[47:0], rnd2[47:0]);
        end
      end
    end

    drain_results();
    if (fails == 0 && pending == 0) begin
      $display("per_peer_token_bucket_queue_core_tb: PASS");
    end else begin
      $display("per_peer_token_bucket_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pptbq_pkg.sv
hdl/pptbq_ram.sv
hdl/pptbq_refill.sv
hdl/per_peer_token_bucket_queue_core.sv
hdl/pptbq_checker.sv
tb/pptbq_admission_checker.sv
tb/per_peer_token_bucket_queue_core_tb.sv
